@@ rtl/jtsg_pkg.sv @@
`timescale 1ns / 1ps

package jtsg_pkg;

    // Sample count limits and fixed-point widths (Q1.24 on 25 bits)
    localparam int MAX_SAMPLES = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int REM_W       = 4;
    localparam int Q_W         = 25;
    localparam int AMP_W       = 16;
    localparam int U_W         = 24;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 28;

    localparam logic [Q_W-1:0]   ONE_Q24 = 25'h100_0000;
    localparam logic [AMP_W-1:0] AMP_MAX = 16'h8000;

    // splitmix64 finalizer multipliers
    localparam logic [63:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HASH_SEED    = 2'd0,
        CFG_SAMPLE_COUNT = 2'd1,
        CFG_JITTER_AMP   = 2'd2
    } cfg_index_t;

    // Per-sample tag that travels down the pipeline with its valid bit
    typedef struct packed {
        logic [31:0]      particle;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [Q_W-1:0]   center;
    } sample_tag_t;

    // Sample count forced into 1..MAX_SAMPLES
    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > CNT_W'(MAX_SAMPLES)) begin
            r = CNT_W'(MAX_SAMPLES);
        end
        return r;
    endfunction

    // Amplitude limited to one half
    function automatic logic [AMP_W-1:0] sat_amp(input logic [AMP_W-1:0] a);
        return (a > AMP_MAX) ? AMP_MAX : a;
    endfunction

    // floor(2^24 / t)
    function automatic logic [Q_W-1:0] weight_of(input logic [CNT_W-1:0] t);
        logic [Q_W-1:0] w;
        case (t)
            5'd1:    w = 25'd16777216;
            5'd2:    w = 25'd8388608;
            5'd3:    w = 25'd5592405;
            5'd4:    w = 25'd4194304;
            5'd5:    w = 25'd3355443;
            5'd6:    w = 25'd2796202;
            5'd7:    w = 25'd2396745;
            5'd8:    w = 25'd2097152;
            5'd9:    w = 25'd1864135;
            5'd10:   w = 25'd1677721;
            5'd11:   w = 25'd1525201;
            5'd12:   w = 25'd1398101;
            5'd13:   w = 25'd1290555;
            5'd14:   w = 25'd1198372;
            5'd15:   w = 25'd1118481;
            5'd16:   w = 25'd1048576;
            default: w = 25'd16777216;
        endcase
        return w;
    endfunction

    // 2^23 mod t
    function automatic logic [REM_W-1:0] rem_half_of(input logic [CNT_W-1:0] t);
        logic [REM_W-1:0] r;
        case (t)
            5'd3:    r = 4'd2;
            5'd5:    r = 4'd3;
            5'd6:    r = 4'd2;
            5'd7:    r = 4'd4;
            5'd9:    r = 4'd5;
            5'd10:   r = 4'd8;
            5'd11:   r = 4'd8;
            5'd12:   r = 4'd8;
            5'd13:   r = 4'd7;
            5'd14:   r = 4'd4;
            5'd15:   r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // 2^24 mod t
    function automatic logic [REM_W-1:0] rem_one_of(input logic [CNT_W-1:0] t);
        logic [REM_W-1:0] r;
        case (t)
            5'd3:    r = 4'd1;
            5'd5:    r = 4'd1;
            5'd6:    r = 4'd4;
            5'd7:    r = 4'd1;
            5'd9:    r = 4'd1;
            5'd10:   r = 4'd6;
            5'd11:   r = 4'd5;
            5'd12:   r = 4'd4;
            5'd13:   r = 4'd1;
            5'd14:   r = 4'd8;
            5'd15:   r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // ceil(2^28 / t): exact quotient for dividends below 2^24
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] t);
        logic [RECIP_W-1:0] m;
        case (t)
            5'd1:    m = 29'd268435456;
            5'd2:    m = 29'd134217728;
            5'd3:    m = 29'd89478486;
            5'd4:    m = 29'd67108864;
            5'd5:    m = 29'd53687092;
            5'd6:    m = 29'd44739243;
            5'd7:    m = 29'd38347923;
            5'd8:    m = 29'd33554432;
            5'd9:    m = 29'd29826162;
            5'd10:   m = 29'd26843546;
            5'd11:   m = 29'd24403224;
            5'd12:   m = 29'd22369622;
            5'd13:   m = 29'd20648882;
            5'd14:   m = 29'd19173962;
            5'd15:   m = 29'd17895698;
            5'd16:   m = 29'd16777216;
            default: m = 29'd268435456;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/jtsg_expander.sv @@
`timescale 1ns / 1ps

module jtsg_expander import jtsg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [CNT_W-1:0]  t_eff,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_particle_index,
    output logic              out_valid,
    output sample_tag_t       out_tag
);

    logic                busy_reg, busy_next;
    logic [31:0]         part_reg, part_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [Q_W-1:0]      cq_reg, cq_next;
    logic [REM_W-1:0]    cr_reg, cr_next;

    logic                is_last;
    logic                accept;
    logic [Q_W-1:0]      weight;
    logic [CNT_W-1:0]    r_sum;
    logic                carry;

    assign weight  = weight_of(t_eff);
    assign is_last = (({1'b0, idx_reg} + CNT_W'(1)) == t_eff);
    assign s_ready = !busy_reg || (adv && is_last);
    assign accept  = s_valid && s_ready;

    // center(s+1) = center(s) + 2^24/t, quotient and remainder kept apart
    assign r_sum = {1'b0, cr_reg} + {1'b0, rem_one_of(t_eff)};
    assign carry = (r_sum >= t_eff);

    always_comb begin
        busy_next = busy_reg;
        part_next = part_reg;
        idx_next  = idx_reg;
        cq_next   = cq_reg;
        cr_next   = cr_reg;
        if (accept) begin
            busy_next = 1'b1;
            part_next = s_particle_index;
            idx_next  = '0;
            cq_next   = {1'b0, weight[Q_W-1:1]};
            cr_next   = rem_half_of(t_eff);
        end else if (busy_reg && adv) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
                cq_next  = cq_reg + weight + Q_W'(carry);
                cr_next  = carry ? REM_W'(r_sum - t_eff) : r_sum[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
        idx_reg  <= idx_next;
        cq_reg   <= cq_next;
        cr_reg   <= cr_next;
    end

    assign out_valid       = busy_reg;
    assign out_tag.particle = part_reg;
    assign out_tag.idx      = idx_reg;
    assign out_tag.last     = is_last;
    assign out_tag.center   = cq_reg;

    // no new word taken while samples of the current particle remain
    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !is_last |-> !s_ready)
        else $error("expander accepted a word mid-particle");

    a_start_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> busy_reg && (idx_reg == '0))
        else $error("expansion did not start at sample zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !adv |=> busy_reg && $stable(idx_reg) && $stable(cq_reg))
        else $error("expander moved during a stall");

endmodule

@@ rtl/jtsg_hash.sv @@
`timescale 1ns / 1ps

module jtsg_hash import jtsg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [63:0]       seed,
    input  logic              in_valid,
    input  sample_tag_t       in_tag,
    output logic              out_valid,
    output sample_tag_t       out_tag,
    output logic [U_W-1:0]    out_u
);

    // stage 1: key, first xor-shift, partial products with C1
    logic               v1_reg;
    sample_tag_t        tag1_reg;
    logic [63:0]        pll1_reg;
    logic [31:0]        pxa1_reg, pxb1_reg;

    // stage 2: product sum, second xor-shift
    logic               v2_reg;
    sample_tag_t        tag2_reg;
    logic [63:0]        w2_reg;

    // stage 3: partial products with C2
    logic               v3_reg;
    sample_tag_t        tag3_reg;
    logic [63:0]        pll3_reg;
    logic [31:0]        pxa3_reg, pxb3_reg;

    // stage 4: product sum, final xor-shift, low 24 bits
    logic               v4_reg;
    sample_tag_t        tag4_reg;
    logic [U_W-1:0]     u4_reg;

    logic [63:0]        key, xs1, m1, w2_next, m2, h;
    logic [63:0]        pll1_next, pll3_next;
    logic [31:0]        pxa1_next, pxb1_next, pxa3_next, pxb3_next;

    assign key = seed ^ {in_tag.particle, 32'h0} ^ {{(64-IDX_W){1'b0}}, in_tag.idx};
    assign xs1 = key ^ (key >> 30);

    // low 64 bits of a 64x64 product from three 32x32 parts
    assign pll1_next = xs1[31:0] * MIX_C1[31:0];
    assign pxa1_next = xs1[63:32] * MIX_C1[31:0];
    assign pxb1_next = xs1[31:0] * MIX_C1[63:32];

    assign m1      = pll1_reg + {pxa1_reg + pxb1_reg, 32'h0};
    assign w2_next = m1 ^ (m1 >> 27);

    assign pll3_next = w2_reg[31:0] * MIX_C2[31:0];
    assign pxa3_next = w2_reg[63:32] * MIX_C2[31:0];
    assign pxb3_next = w2_reg[31:0] * MIX_C2[63:32];

    assign m2 = pll3_reg + {pxa3_reg + pxb3_reg, 32'h0};
    assign h  = m2 ^ (m2 >> 31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= in_tag;
            pll1_reg <= pll1_next;
            pxa1_reg <= pxa1_next;
            pxb1_reg <= pxb1_next;
            tag2_reg <= tag1_reg;
            w2_reg   <= w2_next;
            tag3_reg <= tag2_reg;
            pll3_reg <= pll3_next;
            pxa3_reg <= pxa3_next;
            pxb3_reg <= pxb3_next;
            tag4_reg <= tag3_reg;
            u4_reg   <= h[U_W-1:0];
        end
    end

    assign out_valid = v4_reg;
    assign out_tag   = tag4_reg;
    assign out_u     = u4_reg;

endmodule

@@ rtl/jtsg_time.sv @@
`timescale 1ns / 1ps

module jtsg_time import jtsg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [CNT_W-1:0]  t_eff,
    input  logic [AMP_W-1:0]  amp,
    input  logic              in_valid,
    input  sample_tag_t       in_tag,
    input  logic [U_W-1:0]    in_u,
    output logic              m_valid,
    output logic [31:0]       m_out_particle,
    output logic [IDX_W-1:0]  m_sample_index,
    output logic [Q_W-1:0]    m_sample_time,
    output logic [Q_W-1:0]    m_sample_weight,
    output logic              m_last_sample
);

    localparam int P_W    = 43;
    localparam int Q27_W  = 27;
    localparam int PROD_W = 53;

    // stage 1: (2u - 2^24) * amp
    logic                       v1_reg;
    sample_tag_t                tag1_reg;
    logic signed [P_W-1:0]      p1_reg;

    // stage 2: floor shift, magnitude times reciprocal of t
    logic                       v2_reg;
    sample_tag_t                tag2_reg;
    logic [PROD_W-1:0]          prod2_reg;
    logic                       neg2_reg;

    // stage 3: output word
    logic                       m_valid_reg;
    logic [31:0]                part_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [Q_W-1:0]             time_reg, time_next;
    logic [Q_W-1:0]             weight_reg;
    logic                       last_reg;

    logic signed [25:0]         d;
    logic signed [P_W-1:0]      p_next;
    logic signed [Q27_W-1:0]    q;
    logic [Q27_W-1:0]           mag27;
    logic [U_W-1:0]             mag;
    logic [PROD_W-1:0]          prod_next;
    logic [Q_W-1:0]             quo;
    logic signed [Q27_W-1:0]    jit;
    logic signed [Q27_W-1:0]    tsum;

    assign d      = $signed({1'b0, in_u, 1'b0}) - $signed({2'b01, 24'h0});
    assign p_next = d * $signed({1'b0, amp});

    // arithmetic shift by 16 is the upper bits; |q| <= 2^23
    assign q         = p1_reg[P_W-1:16];
    assign mag27     = q[Q27_W-1] ? Q27_W'(-q) : q;
    assign mag       = mag27[U_W-1:0];
    assign prod_next = mag * recip_of(t_eff);

    // truncating divide, sign restored, then clamp to [0, 1.0]
    assign quo  = prod2_reg[PROD_W-1:RECIP_SHIFT];
    assign jit  = neg2_reg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    assign tsum = $signed({2'b00, tag2_reg.center}) + jit;

    always_comb begin
        if (tsum < 0) begin
            time_next = '0;
        end else if (tsum > $signed({2'b00, ONE_Q24})) begin
            time_next = ONE_Q24;
        end else begin
            time_next = tsum[Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg   <= in_tag;
            p1_reg     <= p_next;
            tag2_reg   <= tag1_reg;
            prod2_reg  <= prod_next;
            neg2_reg   <= q[Q27_W-1];
            part_reg   <= tag2_reg.particle;
            idx_reg    <= tag2_reg.idx;
            last_reg   <= tag2_reg.last;
            time_reg   <= time_next;
            weight_reg <= weight_of(t_eff);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_particle  = part_reg;
    assign m_sample_index  = idx_reg;
    assign m_sample_time   = time_reg;
    assign m_sample_weight = weight_reg;
    assign m_last_sample   = last_reg;

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> time_reg <= ONE_Q24)
        else $error("sample time above 1.0");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && last_reg |-> (({1'b0, idx_reg} + CNT_W'(1)) == t_eff))
        else $error("last flag on wrong sample index");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !adv |=> v2_reg && $stable(prod2_reg) && $stable(neg2_reg))
        else $error("divide stage moved during a stall");

endmodule

@@ rtl/jittered_temporal_sample_generator_core.sv @@
`timescale 1ns / 1ps

// Jittered temporal sample generator.
// Input channel (s_valid/s_ready): one word per particle index. Each word expands
// into T results, T = sample_count held in 1..16, one per cycle when not stalled on the result
// channel (m_valid/m_ready): particle, sample index, jittered Q1.24 time,
// weight 1/T and a last flag on sample T-1.
// The first sample of a particle passes the expander register, four hash stages,
// two jitter stages and the output register. Throughput: one result per cycle
// while m_ready does not stall the pipeline; a particle occupies the expander
// until its last sample leaves it, and the next word is accepted in the cycle
// its predecessor's last sample leaves the expander.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr (0 seed,
// 1 sample count, 2 jitter amplitude); write only while idle.
// Reset (aresetn low, synchronous) empties the pipeline and restores seed 0,
// count 1 and amplitude 0.
// A stalled receiver freezes the whole pipeline in place; nothing is dropped
// or repeated, and s_ready is low while a busy expander cannot advance.
module jittered_temporal_sample_generator_core import jtsg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [63:0]       cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_particle_index,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_out_particle,
    output logic [IDX_W-1:0]  m_sample_index,
    output logic [Q_W-1:0]    m_sample_time,
    output logic [Q_W-1:0]    m_sample_weight,
    output logic              m_last_sample
);

    logic [63:0]         seed_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [AMP_W-1:0]    amp_reg;

    logic [CNT_W-1:0]    t_eff;
    logic [AMP_W-1:0]    amp_eff;
    logic                adv;

    logic                exp_valid;
    sample_tag_t         exp_tag;
    logic                hash_valid;
    sample_tag_t         hash_tag;
    logic [U_W-1:0]      hash_u;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= '0;
            count_reg <= CNT_W'(1);
            amp_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_HASH_SEED:    seed_reg  <= cfg_wr_data;
                CFG_SAMPLE_COUNT: count_reg <= cfg_wr_data[CNT_W-1:0];
                CFG_JITTER_AMP:   amp_reg   <= cfg_wr_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign t_eff   = sat_count(count_reg);
    assign amp_eff = sat_amp(amp_reg);

    // whole pipeline advances unless the output word is held
    assign adv = !m_valid || m_ready;

    jtsg_expander u_expander (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .adv              (adv),
        .t_eff            (t_eff),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_particle_index (s_particle_index),
        .out_valid        (exp_valid),
        .out_tag          (exp_tag)
    );

    jtsg_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .seed      (seed_reg),
        .in_valid  (exp_valid),
        .in_tag    (exp_tag),
        .out_valid (hash_valid),
        .out_tag   (hash_tag),
        .out_u     (hash_u)
    );

    jtsg_time u_time (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .t_eff           (t_eff),
        .amp             (amp_eff),
        .in_valid        (hash_valid),
        .in_tag          (hash_tag),
        .in_u            (hash_u),
        .m_valid         (m_valid),
        .m_out_particle  (m_out_particle),
        .m_sample_index  (m_sample_index),
        .m_sample_time   (m_sample_time),
        .m_sample_weight (m_sample_weight),
        .m_last_sample   (m_last_sample)
    );

endmodule

@@ sim/jittered_temporal_sample_generator_core_tb.sv @@
`timescale 1ns / 1ps

module jittered_temporal_sample_generator_core_tb;
    import jtsg_pkg::*;

    // splitmix64 finalizer multipliers
    localparam logic [63:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;
    localparam longint Q24_UNIT     = 64'sd16777216;
    localparam longint AMP_LIMIT    = 64'sd32768;
    localparam int     FLUSH_CYCLES = 16;
    localparam int     RANDOM_PHASES = 10;
    localparam int     WORDS_PER_PHASE = 20;

    typedef struct packed {
        logic [31:0]      particle;
        logic [IDX_W-1:0] idx;
        logic [Q_W-1:0]   sample_time;
        logic [Q_W-1:0]   weight;
        logic             is_last;
    } sample_word_t;

    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              cfg_wr_en        = 1'b0;
    logic [1:0]        cfg_addr         = CFG_HASH_SEED;
    logic [63:0]       cfg_wr_data      = '0;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic [31:0]       s_particle_index = '0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    logic [31:0]       m_out_particle;
    logic [IDX_W-1:0]  m_sample_index;
    logic [Q_W-1:0]    m_sample_time;
    logic [Q_W-1:0]    m_sample_weight;
    logic              m_last_sample;

    // Shadow copy of the block's registers
    logic [63:0]       seed_q  = '0;
    logic [CNT_W-1:0]  count_q = CNT_W'(1);
    logic [AMP_W-1:0]  amp_q   = '0;

    logic [31:0]       pending_particles[$];
    sample_word_t      expected_samples[$];
    int                mismatch_count = 0;
    bit                quiet_mode     = 1'b0;
    bit                hold_sender    = 1'b0;

    jittered_temporal_sample_generator_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_particle_index (s_particle_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_particle   (m_out_particle),
        .m_sample_index   (m_sample_index),
        .m_sample_time    (m_sample_time),
        .m_sample_weight  (m_sample_weight),
        .m_last_sample    (m_last_sample)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Append a particle to the sender's queue
    function automatic void add_particle(input logic [31:0] p);
        pending_particles = {pending_particles, p};
    endfunction

    // Append a predicted word to the scoreboard
    function automatic void add_expected(input sample_word_t w);
        expected_samples = {expected_samples, w};
    endfunction

    function automatic logic [63:0] splitmix_finalize(input logic [63:0] v);
        logic [63:0] x;
        x = v ^ (v >> 30);
        x = x * MIX_MUL_A;
        x = x ^ (x >> 27);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 31);
        return x;
    endfunction

    // Expand one particle into its jittered samples
    function automatic void predict_samples(input logic [31:0] particle);
        longint       t;
        longint       amp;
        longint       wgt;
        longint       s;
        longint       u;
        longint       center;
        longint       jit;
        longint       tq;
        logic [63:0]  h;
        sample_word_t w;
        t = longint'(count_q);
        if (t < 1) t = 1;
        if (t > MAX_SAMPLES) t = MAX_SAMPLES;
        amp = longint'(amp_q);
        if (amp > AMP_LIMIT) amp = AMP_LIMIT;
        wgt = Q24_UNIT / t;
        for (s = 0; s < t; s++) begin
            h = splitmix_finalize(seed_q ^ {particle, 32'h0} ^ 64'(s));
            u = longint'(h[23:0]);
            center = ((2 * s + 1) <<< 23) / t;
            // floor shift, then divide truncating toward zero
            jit = (((2 * u - Q24_UNIT) * amp) >>> 16) / t;
            tq = center + jit;
            if (tq < 0) tq = 0;
            if (tq > Q24_UNIT) tq = Q24_UNIT;
            w.particle    = particle;
            w.idx         = s[IDX_W-1:0];
            w.sample_time = tq[Q_W-1:0];
            w.weight      = wgt[Q_W-1:0];
            w.is_last     = (s == t - 1);
            add_expected(w);
        end
    endfunction

    // Register write, only issued while the block is idle
    task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        case (idx)
            CFG_HASH_SEED:    seed_q  = data;
            CFG_SAMPLE_COUNT: count_q = data[CNT_W-1:0];
            CFG_JITTER_AMP:   amp_q   = data[AMP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for every queued word to go in and every sample to come out
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_particles.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (FLUSH_CYCLES) @(negedge aclk);
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_samples(s_particle_index);
            if (!s_valid || s_ready) begin
                if (pending_particles.size() != 0 && !hold_sender &&
                    (quiet_mode || $urandom_range(0, 99) >= 25)) begin
                    s_valid          <= 1'b1;
                    s_particle_index <= pending_particles.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge aclk) begin
        sample_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_mode || ($urandom_range(0, 99) >= 25);
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: particle %h sample %0d time %0d",
                                 m_out_particle, m_sample_index, m_sample_time);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_out_particle !== want.particle || m_sample_index !== want.idx ||
                        m_sample_time !== want.sample_time ||
                        m_sample_weight !== want.weight || m_last_sample !== want.is_last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("expected p=%h s=%0d t=%0d w=%0d last=%0b",
                                     want.particle, want.idx, want.sample_time,
                                     want.weight, want.is_last);
                            $display("  actual p=%h s=%0d t=%0d w=%0d last=%0b",
                                     m_out_particle, m_sample_index, m_sample_time,
                                     m_sample_weight, m_last_sample);
                        end
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        int          k;
        int          n;
        int          pick;
        logic [63:0] data;
        logic [31:0] p;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: one sample, no jitter, zero seed
        add_particle(32'h0000_0000);
        add_particle(32'hFFFF_FFFF);
        wait_idle();

        // Zero count saturates to one, oversized amplitude saturates to one half
        write_reg(CFG_SAMPLE_COUNT, 64'd0);
        write_reg(CFG_JITTER_AMP, 64'h0000_0000_0000_FFFF);
        write_reg(CFG_HASH_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_particle(32'h8000_0000);
        add_particle(32'h7FFF_FFFF);
        add_particle(32'h0000_0000);
        wait_idle();

        // Count above the maximum saturates to sixteen
        write_reg(CFG_SAMPLE_COUNT, 64'd31);
        write_reg(CFG_JITTER_AMP, 64'h8000);
        write_reg(CFG_HASH_SEED, 64'h0);
        add_particle(32'h0000_0000);
        add_particle(32'hFFFF_FFFF);
        add_particle(32'h5A5A_A5A5);
        wait_idle();

        write_reg(CFG_SAMPLE_COUNT, 64'd16);
        write_reg(CFG_JITTER_AMP, 64'h0);
        write_reg(CFG_HASH_SEED, 64'h8000_0000_0000_0000);
        add_particle(32'h0000_0001);
        wait_idle();

        write_reg(CFG_SAMPLE_COUNT, 64'd3);
        write_reg(CFG_JITTER_AMP, 64'h8001);
        write_reg(CFG_HASH_SEED, 64'h0123_4567_89AB_CDEF);
        add_particle(32'h0000_0002);
        add_particle(32'h0000_0003);
        wait_idle();

        write_reg(CFG_SAMPLE_COUNT, 64'd17);
        write_reg(CFG_JITTER_AMP, 64'h7FFF);
        add_particle(32'hFFFF_FFFE);
        wait_idle();

        // Random phases, each with fresh settings
        for (k = 0; k < RANDOM_PHASES; k++) begin
            quiet_mode = (k == 4);

            data = {$urandom, $urandom};
            if (k == 7) data = '0;
            write_reg(CFG_HASH_SEED, data);

            data = (k % 2 == 1) ? {$urandom, $urandom} : 64'h0;
            pick = $urandom_range(0, 9);
            data[CNT_W-1:0] = (pick < 7) ? CNT_W'($urandom_range(1, 16))
                                         : CNT_W'($urandom_range(0, 31));
            write_reg(CFG_SAMPLE_COUNT, data);

            data = (k % 2 == 1) ? {$urandom, $urandom} : 64'h0;
            pick = $urandom_range(0, 9);
            if (pick < 6) data[AMP_W-1:0] = AMP_W'($urandom_range(0, 32768));
            else if (pick < 8) data[AMP_W-1:0] = AMP_MAX;
            else data[AMP_W-1:0] = AMP_W'($urandom_range(0, 65535));
            write_reg(CFG_JITTER_AMP, data);

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) p = 32'h0;
                else if (pick == 1) p = 32'hFFFF_FFFF;
                else p = $urandom;
                add_particle(p);
            end

            // Hold the sender mid-phase until the output side runs dry
            if (k == 2) begin
                while (pending_particles.size() > WORDS_PER_PHASE / 2) @(negedge aclk);
                hold_sender = 1'b1;
                do @(negedge aclk);
                while (s_valid || expected_samples.size() != 0);
                hold_sender = 1'b0;
            end
            wait_idle();
        end

        quiet_mode = 1'b0;
        repeat (FLUSH_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("jittered_temporal_sample_generator_core test passed");
        end else begin
            $display("jittered_temporal_sample_generator_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("jittered_temporal_sample_generator_core test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/jtsg_pkg.sv
rtl/jtsg_expander.sv
rtl/jtsg_hash.sv
rtl/jtsg_time.sv
rtl/jittered_temporal_sample_generator_core.sv
sim/jittered_temporal_sample_generator_core_tb.sv
